>>> design/pbwb_pkg.sv
package pbwb_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int ROT_FRAC        = 28;
    localparam int SCALE_FRAC      = 8;
    localparam int TERM_SHIFT      = ROT_FRAC + SCALE_FRAC + COORD_FRAC_BITS - COORD_FRAC_BITS;
    localparam int LO_SPLIT        = 24;

    localparam logic [2:0] REG_BOX_LOADED = 3'd0;
    localparam logic [2:0] REG_MIN_X      = 3'd1;
    localparam logic [2:0] REG_MIN_Y      = 3'd2;
    localparam logic [2:0] REG_MIN_Z      = 3'd3;
    localparam logic [2:0] REG_MAX_X      = 3'd4;
    localparam logic [2:0] REG_MAX_Y      = 3'd5;
    localparam logic [2:0] REG_MAX_Z      = 3'd6;

    typedef logic signed [31:0] coord_t;
    typedef logic        [32:0] rmag_t;
    typedef logic        [46:0] sbmag_t;
    typedef logic signed [44:0] term_t;

    // handshake moving between pipeline parts
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctrl_t;

endpackage

>>> design/pbwb_prep.sv
module pbwb_prep import pbwb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pipe_ctrl_t  ctrl_in,
    input  coord_t      pos [3],
    input  logic [15:0] quat_w,
    input  logic [15:0] quat_x,
    input  logic [15:0] quat_y,
    input  logic [15:0] quat_z,
    input  logic [15:0] scale [3],
    input  coord_t      bound_lo [3],
    input  coord_t      bound_hi [3],
    output logic        valid_out,
    output rmag_t       r_mag [3][3],
    output logic        r_neg [3][3],
    output sbmag_t      sb_mag [3][2],
    output logic        sb_neg [3][2],
    output coord_t      t_out [3]
);

    localparam logic signed [34:0] ONE_ROT = 35'sd1 <<< ROT_FRAC;

    logic va_reg, vb_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic signed [47:0] sb_reg [3][2];
    coord_t ta_reg [3];
    rmag_t  rm_reg [3][3];
    logic   rn_reg [3][3];
    sbmag_t sm_reg [3][2];
    logic   sn_reg [3][2];
    coord_t tb_reg [3];
    logic signed [34:0] rv [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            va_reg <= ctrl_in.valid;
            vb_reg <= va_reg;
        end
    end

    // stage a: quaternion products and scaled bounds
    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            xx_reg <= $signed(quat_x) * $signed(quat_x);
            yy_reg <= $signed(quat_y) * $signed(quat_y);
            zz_reg <= $signed(quat_z) * $signed(quat_z);
            xy_reg <= $signed(quat_x) * $signed(quat_y);
            xz_reg <= $signed(quat_x) * $signed(quat_z);
            yz_reg <= $signed(quat_y) * $signed(quat_z);
            wx_reg <= $signed(quat_w) * $signed(quat_x);
            wy_reg <= $signed(quat_w) * $signed(quat_y);
            wz_reg <= $signed(quat_w) * $signed(quat_z);
            for (int c = 0; c < 3; c++) begin
                sb_reg[c][0] <= $signed({1'b0, scale[c]}) * bound_lo[c];
                sb_reg[c][1] <= $signed({1'b0, scale[c]}) * bound_hi[c];
                ta_reg[c]    <= pos[c];
            end
        end
    end

    always_comb begin
        rv[0][0] = ONE_ROT - 35'sd2 * (35'(yy_reg) + 35'(zz_reg));
        rv[0][1] = 35'sd2 * (35'(xy_reg) - 35'(wz_reg));
        rv[0][2] = 35'sd2 * (35'(xz_reg) + 35'(wy_reg));
        rv[1][0] = 35'sd2 * (35'(xy_reg) + 35'(wz_reg));
        rv[1][1] = ONE_ROT - 35'sd2 * (35'(xx_reg) + 35'(zz_reg));
        rv[1][2] = 35'sd2 * (35'(yz_reg) - 35'(wx_reg));
        rv[2][0] = 35'sd2 * (35'(xz_reg) - 35'(wy_reg));
        rv[2][1] = 35'sd2 * (35'(yz_reg) + 35'(wx_reg));
        rv[2][2] = ONE_ROT - 35'sd2 * (35'(xx_reg) + 35'(yy_reg));
    end

    // stage b: rotation terms to sign and magnitude
    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    rn_reg[i][c] <= rv[i][c][34];
                    rm_reg[i][c] <= rv[i][c][34] ? 33'(-rv[i][c]) : 33'(rv[i][c]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 2; k++) begin
                    sn_reg[c][k] <= sb_reg[c][k][47];
                    sm_reg[c][k] <= sb_reg[c][k][47] ? 47'(-sb_reg[c][k])
                                                     : 47'(sb_reg[c][k]);
                end
                tb_reg[c] <= ta_reg[c];
            end
        end
    end

    assign valid_out = vb_reg;
    assign r_mag     = rm_reg;
    assign r_neg     = rn_reg;
    assign sb_mag    = sm_reg;
    assign sb_neg    = sn_reg;
    assign t_out     = tb_reg;

endmodule

>>> design/pbwb_terms.sv
module pbwb_terms import pbwb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_ctrl_t ctrl_in,
    input  rmag_t      r_mag [3][3],
    input  logic       r_neg [3][3],
    input  sbmag_t     sb_mag [3][2],
    input  logic       sb_neg [3][2],
    input  coord_t     t_in [3],
    output logic       valid_out,
    output term_t      term [3][3][2],
    output coord_t     t_out [3]
);

    localparam int AW = 33 + 47 - LO_SPLIT;
    localparam int BW = 33 + LO_SPLIT;
    localparam int SW = 33 + 47 + 1;

    logic vc_reg, vd_reg;
    logic [AW-1:0] a_reg [3][3][2];
    logic [BW-1:0] b_reg [3][3][2];
    logic          n_reg [3][3][2];
    coord_t        tc_reg [3];
    coord_t        td_reg [3];
    term_t         q_reg [3][3][2];
    logic [SW-1:0] sum [3][3][2];
    logic [44:0]   qm [3][3][2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            vc_reg <= ctrl_in.valid;
            vd_reg <= vc_reg;
        end
    end

    // stage c: split products on the scaled bound
    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 2; k++) begin
                        a_reg[i][c][k] <= AW'(r_mag[i][c] * sb_mag[c][k][46:LO_SPLIT]);
                        b_reg[i][c][k] <= BW'(r_mag[i][c] * sb_mag[c][k][LO_SPLIT-1:0]);
                        n_reg[i][c][k] <= r_neg[i][c] ^ sb_neg[c][k];
                    end
                end
                tc_reg[i] <= t_in[i];
            end
        end
    end

    // round half away from zero on the magnitude, then apply sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 2; k++) begin
                    sum[i][c][k] = (SW'(a_reg[i][c][k]) << LO_SPLIT) + SW'(b_reg[i][c][k])
                                   + (SW'(1) << (TERM_SHIFT - 1));
                    qm[i][c][k]  = sum[i][c][k][TERM_SHIFT+44:TERM_SHIFT];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int k = 0; k < 2; k++) begin
                        q_reg[i][c][k] <= n_reg[i][c][k] ? -$signed(qm[i][c][k])
                                                         : $signed(qm[i][c][k]);
                    end
                end
                td_reg[i] <= tc_reg[i];
            end
        end
    end

    assign valid_out = vd_reg;
    assign term      = q_reg;
    assign t_out     = td_reg;

endmodule

>>> design/pbwb_reduce.sv
module pbwb_reduce import pbwb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_ctrl_t ctrl_in,
    input  logic       box_loaded,
    input  term_t      term [3][3][2],
    input  coord_t     t_in [3],
    output logic       valid_out,
    output coord_t     world_min [3],
    output coord_t     world_max [3]
);

    localparam logic signed [46:0] SAT_HI = 47'sd2147483647;
    localparam logic signed [46:0] SAT_LO = -47'sd2147483648;

    logic ve_reg, vf_reg;
    logic signed [46:0] lo_reg [3];
    logic signed [46:0] hi_reg [3];
    coord_t mn_reg [3];
    coord_t mx_reg [3];
    term_t  tmin [3][3];
    term_t  tmax [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            ve_reg <= ctrl_in.valid;
            vf_reg <= ve_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                if (term[i][c][0] < term[i][c][1]) begin
                    tmin[i][c] = term[i][c][0];
                    tmax[i][c] = term[i][c][1];
                end else begin
                    tmin[i][c] = term[i][c][1];
                    tmax[i][c] = term[i][c][0];
                end
            end
        end
    end

    // stage e: translation plus the chosen corner terms
    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= 47'(t_in[i]) + 47'(tmin[i][0]) + 47'(tmin[i][1])
                             + 47'(tmin[i][2]);
                hi_reg[i] <= 47'(t_in[i]) + 47'(tmax[i][0]) + 47'(tmax[i][1])
                             + 47'(tmax[i][2]);
            end
        end
    end

    // stage f: saturate, zero when no box is loaded
    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                if (!box_loaded) begin
                    mn_reg[i] <= '0;
                    mx_reg[i] <= '0;
                end else begin
                    mn_reg[i] <= (lo_reg[i] > SAT_HI) ? 32'(SAT_HI) :
                                 (lo_reg[i] < SAT_LO) ? 32'(SAT_LO) : 32'(lo_reg[i]);
                    mx_reg[i] <= (hi_reg[i] > SAT_HI) ? 32'(SAT_HI) :
                                 (hi_reg[i] < SAT_LO) ? 32'(SAT_LO) : 32'(hi_reg[i]);
                end
            end
        end
    end

    assign valid_out = vf_reg;
    assign world_min = mn_reg;
    assign world_max = mx_reg;

endmodule

>>> design/posed_box_world_bounds_core.sv
// world-space bounds of a posed local box
// s_ channel: one pose word per handshake (translation, quaternion, scale).
// m_ channel: one bounds word per pose, in the same order.
// cfg channel: register writes, index 0 box_loaded, 1..3 local min x/y/z,
// 4..6 local max x/y/z; index 7 is ignored. cfg_ready is always high.
// one pose is taken every cycle while the receiver keeps up, through the
// six-stage pipeline (quaternion products, rotation terms, split multiply,
// rounding, corner sums, saturation).
// with box_loaded clear every output field is zero.
// reset (aresetn low, synchronous) empties the pipeline and clears the
// configuration registers to zero.
// when m_tready is low with a word waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
module posed_box_world_bounds_core import pbwb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
    output logic [191:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic   box_loaded_reg;
    coord_t lo_reg [3];
    coord_t hi_reg [3];

    pipe_ctrl_t c_prep, c_terms, c_red;
    logic       en;
    coord_t     pos [3];
    logic [15:0] scale [3];
    logic       v_prep, v_terms, v_red;
    rmag_t      r_mag [3][3];
    logic       r_neg [3][3];
    sbmag_t     sb_mag [3][2];
    logic       sb_neg [3][2];
    coord_t     t_prep [3];
    coord_t     t_terms [3];
    term_t      term [3][3][2];
    coord_t     wmin [3];
    coord_t     wmax [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_loaded_reg <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                lo_reg[c] <= '0;
                hi_reg[c] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BOX_LOADED: box_loaded_reg <= cfg_data[0];
                REG_MIN_X:      lo_reg[0] <= cfg_data;
                REG_MIN_Y:      lo_reg[1] <= cfg_data;
                REG_MIN_Z:      lo_reg[2] <= cfg_data;
                REG_MAX_X:      hi_reg[0] <= cfg_data;
                REG_MAX_Y:      hi_reg[1] <= cfg_data;
                REG_MAX_Z:      hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // one enable for every stage: advance unless the output word is stuck
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign pos[0]   = s_tdata[31:0];
    assign pos[1]   = s_tdata[63:32];
    assign pos[2]   = s_tdata[95:64];
    assign scale[0] = s_tdata[175:160];
    assign scale[1] = s_tdata[191:176];
    assign scale[2] = s_tdata[207:192];

    assign c_prep  = '{en: en, valid: s_tvalid};
    assign c_terms = '{en: en, valid: v_prep};
    assign c_red   = '{en: en, valid: v_terms};

    pbwb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   (c_prep),
        .pos       (pos),
        .quat_w    (s_tdata[111:96]),
        .quat_x    (s_tdata[127:112]),
        .quat_y    (s_tdata[143:128]),
        .quat_z    (s_tdata[159:144]),
        .scale     (scale),
        .bound_lo  (lo_reg),
        .bound_hi  (hi_reg),
        .valid_out (v_prep),
        .r_mag     (r_mag),
        .r_neg     (r_neg),
        .sb_mag    (sb_mag),
        .sb_neg    (sb_neg),
        .t_out     (t_prep)
    );

    pbwb_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   (c_terms),
        .r_mag     (r_mag),
        .r_neg     (r_neg),
        .sb_mag    (sb_mag),
        .sb_neg    (sb_neg),
        .t_in      (t_prep),
        .valid_out (v_terms),
        .term      (term),
        .t_out     (t_terms)
    );

    pbwb_reduce u_reduce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_in    (c_red),
        .box_loaded (box_loaded_reg),
        .term       (term),
        .t_in       (t_terms),
        .valid_out  (v_red),
        .world_min  (wmin),
        .world_max  (wmax)
    );

    assign m_tvalid = v_red;
    assign m_tdata  = {wmax[2], wmax[1], wmax[0], wmin[2], wmin[1], wmin[0]};

endmodule

>>> design/pbwb_checker.sv
module pbwb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    // a stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a stuck output word must stop the intake
    a_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked with free output");

endmodule

bind posed_box_world_bounds_core pbwb_checker u_pbwb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
